>>> hdl/twist_to_steer_mode_command_unit_defines.svh
// Assertion macros shared by the drive mode command unit.
`ifndef TWIST_TO_STEER_MODE_COMMAND_UNIT_DEFINES_SVH
`define TWIST_TO_STEER_MODE_COMMAND_UNIT_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define TSM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define TSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tsm_pkg.sv
// Package with mode codes, register indexes and the arctangent table.
`default_nettype none

package tsm_pkg;

  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = 5;
  localparam int ANGLE_W    = 14;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN  = 14'd12868;
  localparam logic [ANGLE_W-1:0] ACK_ANGLE_CAP = 14'd5719;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_ACKERMANN = 2'd0;
  localparam mode_t MODE_PARALLEL  = 2'd1;
  localparam mode_t MODE_SPIN      = 2'd2;
  localparam mode_t MODE_SIDESLIP  = 2'd3;

  localparam logic [2:0] CFG_OLD_VARIANT     = 3'd0;
  localparam logic [2:0] CFG_WHEEL_BASE      = 3'd1;
  localparam logic [2:0] CFG_MIN_TURN_RADIUS = 3'd2;
  localparam logic [2:0] CFG_MAX_STEER_ACK   = 3'd3;
  localparam logic [2:0] CFG_MAX_STEER_PAR   = 3'd4;
  localparam logic [2:0] CFG_MAX_TURN_RATE   = 3'd5;
  localparam logic [2:0] CFG_MAX_LAT_SPEED   = 3'd6;

  // atan(2^-i) in units of 2^-30 rad.
  function automatic logic signed [31:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [31:0] v;
    unique case (idx)
      5'd0:    v = 32'sd843314857;
      5'd1:    v = 32'sd497837829;
      5'd2:    v = 32'sd263043837;
      5'd3:    v = 32'sd133525159;
      5'd4:    v = 32'sd67021687;
      5'd5:    v = 32'sd33543516;
      5'd6:    v = 32'sd16775851;
      5'd7:    v = 32'sd8388437;
      5'd8:    v = 32'sd4194283;
      5'd9:    v = 32'sd2097149;
      5'd10:   v = 32'sd1048576;
      5'd11:   v = 32'sd524288;
      5'd12:   v = 32'sd262144;
      5'd13:   v = 32'sd131072;
      5'd14:   v = 32'sd65536;
      5'd15:   v = 32'sd32768;
      5'd16:   v = 32'sd16384;
      5'd17:   v = 32'sd8192;
      5'd18:   v = 32'sd4096;
      5'd19:   v = 32'sd2048;
      5'd20:   v = 32'sd1024;
      5'd21:   v = 32'sd512;
      5'd22:   v = 32'sd256;
      5'd23:   v = 32'sd128;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/twist_to_steer_mode_command_unit.sv
// Top level: drive mode selection sequencer with shared multiplier.
//
// Channel  Dir  Words
// in_      in   one velocity command per word
// out_     out  one mode and drive command per input word
// cfg_     in   one register write per enabled cycle
//
// Parallel and yawing Ackermann words run the CORDIC vectoring loop and the square root
// loop side by side after two passes through the shared multiplier.
// Other words take only the two passes through the shared multiplier.
// Reset is synchronous and active low and restores the register defaults.
// A result waits in the output register while the next word is taken in.
`default_nettype none

module twist_to_steer_mode_command_unit
  import tsm_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // forward_speed[15:0], lateral_speed[31:16], yaw_rate[47:32]
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // drive_mode[1:0], drive_speed[18:2], steer_angle[33:19], rate_command[49:34]
  output logic [55:0]      out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  `include "twist_to_steer_mode_command_unit_defines.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL1  = 3'd1;
  localparam logic [2:0] S_MUL2  = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_RUN   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]  state_r, state_nxt;

  logic        old_variant_r;
  logic [15:0] wheel_base_r, min_turn_radius_r;
  logic [13:0] max_steer_ack_r, max_steer_par_r;
  logic [14:0] max_turn_rate_r, max_lat_speed_r;
  logic        last_fwd_neg_r;

  logic signed [15:0] fx_r, fy_r, wz_r;
  logic [15:0] afx, afy, awz;
  logic        fx_nz, fy_nz, wz_nz;

  logic [15:0] mul_a, mul_b;
  logic [31:0] prod_r, acc_r;

  logic        unit_start, c_done, s_done, cdone_r, sdone_r, both_done;
  logic [31:0] c_y, c_x;
  logic [ANGLE_W-1:0] c_angle, ang_par, ang_ack0, ang_ack;
  logic [15:0] s_root;

  mode_t              mode_r;
  logic signed [16:0] spd_r;
  logic signed [14:0] st_r;
  logic signed [15:0] rate_r;
  logic               is_slip, is_spin;

  logic        out_valid_r;
  logic [55:0] out_data_r;

  function automatic logic signed [15:0] clamp_sym(input logic signed [15:0] v,
                                                   input logic [14:0] lim);
    logic signed [16:0] l, nl, vv, r;
    l  = $signed({2'b00, lim});
    nl = -l;
    vv = $signed({v[15], v});
    if (vv > l) begin
      r = l;
    end else if (vv < nl) begin
      r = nl;
    end else begin
      r = vv;
    end
    return r[15:0];
  endfunction

  function automatic logic signed [14:0] signed_angle(input logic [ANGLE_W-1:0] a,
                                                      input logic neg);
    logic signed [14:0] p;
    p = $signed({1'b0, a});
    return neg ? -p : p;
  endfunction

  assign afx   = fx_r[15] ? 16'(-fx_r) : 16'(fx_r);
  assign afy   = fy_r[15] ? 16'(-fy_r) : 16'(fy_r);
  assign awz   = wz_r[15] ? 16'(-wz_r) : 16'(wz_r);
  assign fx_nz = fx_r != '0;
  assign fy_nz = fy_r != '0;
  assign wz_nz = wz_r != '0;

  assign is_slip = fy_nz && !fx_nz && old_variant_r;
  assign is_spin = !fy_nz && wz_nz && ({4'd0, afx, 12'd0} < acc_r);

  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = fy_nz ? afx : min_turn_radius_r;
      mul_b = fy_nz ? afx : awz;
    end else begin
      mul_a = fy_nz ? afy : wheel_base_r;
      mul_b = fy_nz ? afy : awz;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign unit_start = (state_r == S_START) && !is_slip && !is_spin && (fy_nz || wz_nz);
  assign c_y        = fy_nz ? {16'd0, afy} : prod_r;
  assign c_x        = fy_nz ? {16'd0, afx} : {3'd0, afx, 13'd0};
  assign both_done  = (cdone_r || c_done) && (sdone_r || s_done);

  tsm_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .y_in  (c_y),
    .x_in  (c_x),
    .done  (c_done),
    .angle (c_angle)
  );

  tsm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (unit_start),
    .radicand (acc_r + prod_r),
    .done     (s_done),
    .root     (s_root)
  );

  assign ang_par  = (c_angle > max_steer_par_r) ? max_steer_par_r : c_angle;
  assign ang_ack0 = (c_angle > ACK_ANGLE_CAP) ? ACK_ANGLE_CAP : c_angle;
  assign ang_ack  = (ang_ack0 > max_steer_ack_r) ? max_steer_ack_r : ang_ack0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) begin
        state_nxt = S_MUL1;
      end
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_START;
      S_START: state_nxt = unit_start ? S_RUN : S_FIN;
      S_RUN:   if (both_done) begin
        state_nxt = S_FIN;
      end
      S_FIN:   if (!out_valid_r || out_tready) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      old_variant_r     <= 1'b0;
      wheel_base_r      <= 16'd2023;
      min_turn_radius_r <= 16'd1925;
      max_steer_ack_r   <= 14'd5719;
      max_steer_par_r   <= 14'd12868;
      max_turn_rate_r   <= 15'd4096;
      max_lat_speed_r   <= 15'd6144;
      last_fwd_neg_r    <= 1'b0;
      out_valid_r       <= 1'b0;
      cdone_r           <= 1'b0;
      sdone_r           <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          CFG_OLD_VARIANT:     old_variant_r     <= cfg_wdata[0];
          CFG_WHEEL_BASE:      wheel_base_r      <= cfg_wdata;
          CFG_MIN_TURN_RADIUS: min_turn_radius_r <= cfg_wdata;
          CFG_MAX_STEER_ACK:   max_steer_ack_r   <= cfg_wdata[13:0];
          CFG_MAX_STEER_PAR:   max_steer_par_r   <= cfg_wdata[13:0];
          CFG_MAX_TURN_RATE:   max_turn_rate_r   <= cfg_wdata[14:0];
          CFG_MAX_LAT_SPEED:   max_lat_speed_r   <= cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (state_r == S_START && fy_nz && !is_slip && fx_nz) begin
        last_fwd_neg_r <= fx_r[15];
      end
      if (unit_start) begin
        cdone_r <= 1'b0;
        sdone_r <= 1'b0;
      end else begin
        if (c_done) begin
          cdone_r <= 1'b1;
        end
        if (s_done) begin
          sdone_r <= 1'b1;
        end
      end
      if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        fx_r <= $signed(in_tdata[15:0]);
        fy_r <= $signed(in_tdata[31:16]);
        wz_r <= $signed(in_tdata[47:32]);
      end
      S_MUL2: acc_r <= prod_r;
      S_START: begin
        spd_r  <= '0;
        st_r   <= '0;
        rate_r <= '0;
        if (is_slip) begin
          mode_r <= MODE_SIDESLIP;
          rate_r <= clamp_sym(fy_r, max_lat_speed_r);
        end else if (fy_nz) begin
          mode_r <= MODE_PARALLEL;
        end else if (is_spin) begin
          mode_r <= MODE_SPIN;
          rate_r <= clamp_sym(wz_r, max_turn_rate_r);
        end else begin
          mode_r <= MODE_ACKERMANN;
          spd_r  <= 17'(fx_r);
        end
      end
      S_RUN: if (both_done) begin
        if (mode_r == MODE_PARALLEL) begin
          if (fx_nz) begin
            st_r  <= signed_angle(ang_par, fy_r[15]);
            spd_r <= fx_r[15] ? -$signed({1'b0, s_root}) : $signed({1'b0, s_root});
          end else begin
            st_r  <= signed_angle(ang_par, last_fwd_neg_r);
            spd_r <= fy_r[15] ? -$signed({1'b0, s_root}) : $signed({1'b0, s_root});
          end
        end else begin
          st_r <= signed_angle(ang_ack, fx_nz && (wz_r[15] != fx_r[15]));
        end
      end
      S_FIN: if (!out_valid_r || out_tready) begin
        out_data_r <= {6'd0, rate_r, st_r, spd_r, mode_r};
      end
      default: ;
    endcase
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `TSM_ASSERT_SAME(a_spin_slip_zero_drive,
    out_tvalid && (out_tdata[1:0] == MODE_SPIN || out_tdata[1:0] == MODE_SIDESLIP),
    out_tdata[33:2] == '0, "spinning or side-slip word carries speed or steer")
  `TSM_ASSERT_SAME(a_ack_steer_cap,
    out_tvalid && out_tdata[1:0] == MODE_ACKERMANN,
    ($signed(out_tdata[33:19]) <= 15'sd5719) && ($signed(out_tdata[33:19]) >= -15'sd5719),
    "Ackermann steer beyond forty degrees")
  `TSM_ASSERT_SAME(a_cordic_done_in_run, c_done, state_r == S_RUN,
    "CORDIC finished outside the run state")
  `TSM_ASSERT_NEXT(a_accept_starts_mul, in_tvalid && in_tready, state_r == S_MUL1,
    "accepted word did not start the multiply passes")

endmodule

`default_nettype wire

>>> hdl/tsm_cordic.sv
// Iterative CORDIC vectoring unit giving atan2 of two unsigned operands.
`default_nettype none

module tsm_cordic
  import tsm_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [31:0]        y_in,
  input  wire logic [31:0]        x_in,
  output logic                    done,
  output logic [ANGLE_W-1:0]      angle
);

  localparam int CW     = 56;
  localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam logic [ATAN_IDX_W-1:0] LAST_IDX = ATAN_IDX_W'(NSTEPS - 1);

  logic signed [CW-1:0]     x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [31:0]       z_r, z_nxt;
  logic [ATAN_IDX_W-1:0]    idx_r;
  logic                     busy_r, fin_r, done_r;
  logic [ANGLE_W-1:0]       angle_r;
  logic [31:0]              z_pos;
  logic [32:0]              z_rnd;
  logic [15:0]              a_raw;
  logic                     y_pos;

  always_comb begin
    xs    = x_r >>> idx_r;
    ys    = y_r >>> idx_r;
    y_pos = !y_r[CW-1] && (y_r != '0);
    if (y_pos) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_lut(idx_r);
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_lut(idx_r);
    end
    z_pos = z_r[31] ? 32'd0 : z_r;
    z_rnd = {1'b0, z_pos} + 33'd65536;
    a_raw = z_rnd[32:17];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        fin_r  <= 1'b0;
      end else if (busy_r) begin
        if (idx_r == LAST_IDX) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= $signed({4'd0, x_in, 20'd0});
      y_r   <= $signed({4'd0, y_in, 20'd0});
      z_r   <= '0;
      idx_r <= '0;
    end else if (busy_r) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      idx_r <= idx_r + 1'b1;
    end
    if (fin_r) begin
      angle_r <= (a_raw > {2'b00, QUARTER_TURN}) ? QUARTER_TURN : a_raw[ANGLE_W-1:0];
    end
  end

  assign done  = done_r;
  assign angle = angle_r;

endmodule

`default_nettype wire

>>> hdl/tsm_isqrt.sv
// Digit-by-digit square root with rounding to nearest.
`default_nettype none

module tsm_isqrt
  import tsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] radicand,
  output logic             done,
  output logic [15:0]      root
);

  logic [31:0] rem_r, root_r, bit_r, rem_nxt, root_nxt, sum;
  logic [3:0]  cnt_r;
  logic        busy_r, fin_r, done_r, ge;
  logic [15:0] root_out_r;

  always_comb begin
    sum      = root_r + bit_r;
    ge       = rem_r >= sum;
    rem_nxt  = ge ? rem_r - sum : rem_r;
    root_nxt = ge ? (root_r >> 1) + bit_r : root_r >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        fin_r  <= 1'b0;
      end else if (busy_r) begin
        if (cnt_r == 4'hF) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= radicand;
      root_r <= '0;
      bit_r  <= 32'h4000_0000;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      bit_r  <= bit_r >> 2;
      cnt_r  <= cnt_r + 1'b1;
    end
    if (fin_r) begin
      root_out_r <= root_r[15:0] + {15'd0, (rem_r > root_r)};
    end
  end

  assign done = done_r;
  assign root = root_out_r;

endmodule

`default_nettype wire
